/* design/tta_pkg.sv */
// tta_pkg: shared types and constants for the tiled texture address generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tta_pkg;

	localparam int Z_WIDTH       = 10;
	localparam int OFFSET_WIDTH  = 32;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 14;
	localparam int LG_WIDTH      = 3;
	localparam int PITCH_HI_W    = 10;
	localparam int HEIGHT_HI_W   = 11;
	localparam int VOL_PROD_W    = Z_WIDTH - 2 + HEIGHT_HI_W;

	localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_MODE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_PITCH    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SURF_HEIGHT  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BYTES_LOG2   = 2'd3;

	// surface settings in the form the datapath uses
	typedef struct packed {
		logic                   volume_mode;
		logic [PITCH_HI_W-1:0]  pitch_hi;   // rounded pitch / 32
		logic [HEIGHT_HI_W-1:0] height_hi;  // rounded height / 16
		logic [LG_WIDTH-1:0]    lg;
	} cfg_t;

endpackage

/* design/tiled_texture_address.sv */
// tiled_texture_address: top level, configuration registers and stream ports
// depends on tta_pkg, tta_coord_mul and tta_swizzle
`timescale 1ns / 1ps

// Block coordinates go in on the s_ stream and tiled byte offsets come out on
// the m_ stream, one result per transaction, in order. The datapath is a
// four-stage pipeline: a new transaction is taken every cycle unless a stall
// from m_tready has filled the stages, and each result passes through stages
// 1 to 4 in order and is presented on m_tdata from the stage 4 register.
// The two multiplies (row/slice product, then times the pitch) each fill one
// stage and set the clock period. Stalls from m_tready back up stage by stage;
// empty stages still accept. Write the four registers only while no
// transaction is in flight; all of them reset to zero.

module tiled_texture_address #(
	parameter int COORD_WIDTH = 13,
	localparam int S_TDATA_WIDTH = ((2 * COORD_WIDTH + tta_pkg::Z_WIDTH + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tta_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tta_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [S_TDATA_WIDTH-1:0]            s_tdata,  // block_x, block_y, block_z
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tta_pkg::OFFSET_WIDTH-1:0]    m_tdata   // byte_offset
);
	import tta_pkg::*;

	logic                     volume_mode_q;
	logic [CFG_DATA_W-1:0]    row_pitch_q, surf_height_q;
	logic [LG_WIDTH-1:0]      lg_q;
	logic [CFG_DATA_W:0]      pitch_rnd, height_rnd;
	cfg_t                     cfg;

	logic                     mid_valid, mid_ready;
	logic [COORD_WIDTH-1:0]   mid_x, mid_y;
	logic [Z_WIDTH-1:0]       mid_z;
	logic [OFFSET_WIDTH-1:0]  mid_lin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_mode_q <= 1'b0;
			row_pitch_q   <= '0;
			surf_height_q <= '0;
			lg_q          <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VOLUME_MODE: volume_mode_q <= cfg_data[0];
				REG_ROW_PITCH:   row_pitch_q   <= cfg_data;
				REG_SURF_HEIGHT: surf_height_q <= cfg_data;
				REG_BYTES_LOG2:  lg_q          <= cfg_data[LG_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	// round up to 32 blocks
	assign pitch_rnd  = {1'b0, row_pitch_q} + (CFG_DATA_W + 1)'(31);
	assign height_rnd = {1'b0, surf_height_q} + (CFG_DATA_W + 1)'(31);

	assign cfg.volume_mode = volume_mode_q;
	assign cfg.pitch_hi    = pitch_rnd[CFG_DATA_W:5];
	assign cfg.height_hi   = {height_rnd[CFG_DATA_W:5], 1'b0};
	assign cfg.lg          = lg_q;

	tta_coord_mul #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.x_in      (s_tdata[COORD_WIDTH-1:0]),
		.y_in      (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.z_in      (s_tdata[2*COORD_WIDTH+Z_WIDTH-1:2*COORD_WIDTH]),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.x_out     (mid_x),
		.y_out     (mid_y),
		.z_out     (mid_z),
		.lin_out   (mid_lin)
	);

	tta_swizzle #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_swz (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (mid_valid),
		.in_ready   (mid_ready),
		.x_in       (mid_x),
		.y_in       (mid_y),
		.z_in       (mid_z),
		.lin_in     (mid_lin),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.offset_out (m_tdata)
	);

endmodule

/* design/tta_coord_mul.sv */
// tta_coord_mul: stages 1 and 2, macro tile row and slice products
// depends on tta_pkg
`timescale 1ns / 1ps

module tta_coord_mul #(
	parameter int COORD_WIDTH = 13
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tta_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [COORD_WIDTH-1:0]        x_in,
	input  logic [COORD_WIDTH-1:0]        y_in,
	input  logic [tta_pkg::Z_WIDTH-1:0]   z_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [COORD_WIDTH-1:0]        x_out,
	output logic [COORD_WIDTH-1:0]        y_out,
	output logic [tta_pkg::Z_WIDTH-1:0]   z_out,
	output logic [tta_pkg::OFFSET_WIDTH-1:0] lin_out
);
	import tta_pkg::*;

	localparam int FLAT_PROD_W = COORD_WIDTH - 5 + PITCH_HI_W;
	localparam int SUM_W       = VOL_PROD_W + 1;
	localparam int OUTER_W     = SUM_W + PITCH_HI_W;

	logic                        valid_s1, valid_s2;
	logic                        ready_s1, ready_s2;
	logic [COORD_WIDTH-1:0]      x_s1, y_s1, x_s2, y_s2;
	logic [Z_WIDTH-1:0]          z_s1, z_s2;
	logic [OFFSET_WIDTH-1:0]     prod_s1, lin_s2;

	logic [FLAT_PROD_W-1:0]      prod_f;
	logic [VOL_PROD_W-1:0]       prod_v;
	logic [SUM_W-1:0]            sum_v;
	logic [OUTER_W-1:0]          outer_v;
	logic [OFFSET_WIDTH-1:0]     lin_next;

	assign ready_s1 = !valid_s1 || ready_s2;
	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = ready_s1;

	// flat: (y/32) * pitch/32, volume: (z/4) * height/16
	assign prod_f = FLAT_PROD_W'(y_in[COORD_WIDTH-1:5]) * FLAT_PROD_W'(cfg.pitch_hi);
	assign prod_v = VOL_PROD_W'(z_in[Z_WIDTH-1:2]) * VOL_PROD_W'(cfg.height_hi);

	// flat: x/32 + row term, volume: (y/16 + slice term) * pitch/32
	assign sum_v   = SUM_W'(y_s1[COORD_WIDTH-1:4]) + SUM_W'(prod_s1[VOL_PROD_W-1:0]);
	assign outer_v = OUTER_W'(sum_v) * OUTER_W'(cfg.pitch_hi);

	always_comb begin
		if (cfg.volume_mode) begin
			lin_next = OFFSET_WIDTH'(outer_v);
		end else begin
			lin_next = OFFSET_WIDTH'(x_s1[COORD_WIDTH-1:5]) + prod_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			x_s1    <= x_in;
			y_s1    <= y_in;
			z_s1    <= z_in;
			prod_s1 <= cfg.volume_mode ? OFFSET_WIDTH'(prod_v) : OFFSET_WIDTH'(prod_f);
		end
		if (ready_s2 && valid_s1) begin
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			z_s2   <= z_s1;
			lin_s2 <= lin_next;
		end
	end

	assign out_valid = valid_s2;
	assign x_out     = x_s2;
	assign y_out     = y_s2;
	assign z_out     = z_s2;
	assign lin_out   = lin_s2;

endmodule

/* design/tta_swizzle.sv */
// tta_swizzle: stages 3 and 4, micro tile interleave and final bit shuffle
// depends on tta_pkg
`timescale 1ns / 1ps

module tta_swizzle #(
	parameter int COORD_WIDTH = 13
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tta_pkg::cfg_t                    cfg,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [COORD_WIDTH-1:0]           x_in,
	input  logic [COORD_WIDTH-1:0]           y_in,
	input  logic [tta_pkg::Z_WIDTH-1:0]      z_in,
	input  logic [tta_pkg::OFFSET_WIDTH-1:0] lin_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tta_pkg::OFFSET_WIDTH-1:0] offset_out
);
	import tta_pkg::*;

	localparam int MICRO_W = 13;
	localparam int SHAMT_W = 4;

	logic                    valid_s3, valid_s4;
	logic                    ready_s3, ready_s4;
	logic [OFFSET_WIDTH-1:0] mix_s3, off_s4;
	logic [2:0]              o1_s3;
	logic [1:0]              xb_s3, yb_s3;

	logic [SHAMT_W-1:0]      sh6, sh7;
	logic [MICRO_W-1:0]      micro_f, micro_v;
	logic [OFFSET_WIDTH-1:0] macro_f, off_f;
	logic [OFFSET_WIDTH-1:0] vsum, vshift, macro_v, zterm, o2_v;
	logic                    sel;
	logic [1:0]              o1_t;
	logic [OFFSET_WIDTH-1:0] mix_next;

	logic [1:0]              flat_q2;
	logic [OFFSET_WIDTH-1:0] flat_final;
	logic [3:0]              a0;
	logic [6:0]              a1;
	logic [OFFSET_WIDTH-1:0] a2, vol_final;

	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s4 = !valid_s4 || out_ready;
	assign in_ready = ready_s3;

	assign sh6 = {1'b0, cfg.lg} + SHAMT_W'(6);
	assign sh7 = {1'b0, cfg.lg} + SHAMT_W'(7);

	// flat micro tile and macro offset
	assign micro_f = MICRO_W'({y_in[3:1], x_in[2:0]}) << cfg.lg;
	assign macro_f = lin_in << sh7;
	assign off_f   = macro_f + OFFSET_WIDTH'({micro_f[MICRO_W-1:4], 5'b0})
		+ OFFSET_WIDTH'(micro_f[3:0]) + OFFSET_WIDTH'({y_in[0], 4'b0});

	// volume stack offset, macro part kept to 28 bits
	assign micro_v = MICRO_W'({y_in[2:1], x_in[2:0]}) << cfg.lg;
	assign vsum    = OFFSET_WIDTH'(x_in[COORD_WIDTH-1:5]) + lin_in;
	assign vshift  = vsum << sh6;
	assign macro_v = {3'b0, vshift[27:0], 1'b0};
	assign zterm   = OFFSET_WIDTH'(z_in[1:0]) << sh6;
	assign o2_v    = ((macro_v + OFFSET_WIDTH'({micro_v[MICRO_W-1:4], 4'b0})) << 1)
		+ OFFSET_WIDTH'(micro_v[3:0]) + zterm + OFFSET_WIDTH'({y_in[0], 4'b0});
	assign sel     = y_in[3] ^ z_in[2];
	assign o1_t    = x_in[4:3] + {sel, 1'b0};

	assign mix_next = cfg.volume_mode ? o2_v : off_f;

	// final bit shuffle on the stage 3 result
	assign flat_q2    = xb_s3 + {yb_s3[1], 1'b0};
	assign flat_final = ({mix_s3[31:9], 9'b0} << 3) + OFFSET_WIDTH'({yb_s3[0], 11'b0})
		+ OFFSET_WIDTH'({mix_s3[8:6], 8'b0}) + OFFSET_WIDTH'({flat_q2, 6'b0})
		+ OFFSET_WIDTH'(mix_s3[5:0]);

	assign a0        = {o1_s3[0], 3'b0} + 4'(mix_s3[8:6]);
	assign a1        = {a0, 3'b0} + {4'b0, o1_s3[2:1], 1'b0};
	assign a2        = OFFSET_WIDTH'({a1, 2'b0}) + {mix_s3[31:9], 9'b0};
	assign vol_final = (a2 << 3) + OFFSET_WIDTH'(mix_s3[5:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= in_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			mix_s3 <= mix_next;
			o1_s3  <= {o1_t, sel};
			xb_s3  <= x_in[4:3];
			// flat mode needs y bits 3 and 4
			yb_s3  <= {y_in[3], y_in[4]};
		end
		if (ready_s4 && valid_s3) begin
			off_s4 <= cfg.volume_mode ? vol_final : flat_final;
		end
	end

	assign out_valid  = valid_s4;
	assign offset_out = off_s4;

endmodule

/* dv/tiled_texture_address_tb.sv */
// tiled_texture_address_tb: self-checking bench for the tiled texture address generator
// streams block coordinates under several surface settings and checks every offset
// depends on tta_pkg and tiled_texture_address
`timescale 1ns / 1ps

class offset_scoreboard;
	bit          vol_mode;
	bit [13:0]   pitch_reg;
	bit [13:0]   height_reg;
	bit [2:0]    lg_reg;
	bit [31:0]   offset_q[$];
	int          errors;
	int          checked;
	int          accepted;

	function void set_surface(bit vm, bit [13:0] pitch, bit [13:0] height, bit [2:0] lg);
		vol_mode   = vm;
		pitch_reg  = pitch;
		height_reg = height;
		lg_reg     = lg;
	endfunction

	function bit [31:0] round32(bit [13:0] v);
		bit [31:0] w;
		w = {18'd0, v};
		return (w + 32'd31) & ~32'd31;
	endfunction

	function bit [31:0] flat_addr(bit [31:0] x, bit [31:0] y);
		bit [31:0] pitch, lg, macro, micro, off;
		pitch = round32(pitch_reg);
		lg    = {29'd0, lg_reg};
		macro = ((x >> 5) + (y >> 5) * (pitch >> 5)) << (lg + 32'd7);
		micro = ((x & 32'd7) + ((y & 32'hE) << 2)) << lg;
		off   = macro + ((micro & ~32'hF) << 1) + (micro & 32'hF) + ((y & 32'd1) << 4);
		return ((off & ~32'h1FF) << 3) + ((y & 32'd16) << 7) + ((off & 32'h1C0) << 2)
			+ (((((y & 32'd8) >> 2) + (x >> 3)) & 32'd3) << 6) + (off & 32'h3F);
	endfunction

	function bit [31:0] volume_addr(bit [31:0] x, bit [31:0] y, bit [31:0] z);
		bit [31:0] pitch, height, lg, outer, macro, micro, sel, o1, o2, a;
		pitch  = round32(pitch_reg);
		height = round32(height_reg);
		lg     = {29'd0, lg_reg};
		outer  = ((y >> 4) + (z >> 2) * (height >> 4)) * (pitch >> 5);
		macro  = ((((x >> 5) + outer) << (lg + 32'd6)) & 32'hFFFFFFF) << 1;
		micro  = ((x & 32'd7) + ((y & 32'd6) << 2)) << lg;
		sel    = ((y >> 3) + (z >> 2)) & 32'd1;
		o1     = sel + ((((x >> 3) + (sel << 1)) & 32'd3) << 1);
		o2     = ((macro + (micro & ~32'd15)) << 1) + (micro & 32'd15)
			+ ((z & 32'd3) << (lg + 32'd6)) + ((y & 32'd1) << 4);
		a = (o1 & 32'd1) << 3;
		a = a + ((o2 >> 6) & 32'd7);
		a = a << 3;
		a = a + (o1 & ~32'd1);
		a = a << 2;
		a = a + (o2 & ~32'd511);
		a = a << 3;
		a = a + (o2 & 32'd63);
		return a;
	endfunction

	function void note_input(bit [12:0] x, bit [12:0] y, bit [9:0] z);
		accepted++;
		if (vol_mode)
			offset_q.push_back(volume_addr({19'd0, x}, {19'd0, y}, {22'd0, z}));
		else
			offset_q.push_back(flat_addr({19'd0, x}, {19'd0, y}));
	endfunction

	task report(string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task check_result(bit [31:0] got);
		bit [31:0] want;
		checked++;
		if (offset_q.size() == 0) begin
			report($sformatf("byte_offset %h with no transaction outstanding", got));
		end else begin
			want = offset_q.pop_front();
			if (got !== want)
				report($sformatf("byte_offset got %h expected %h", got, want));
		end
	endtask

	function int pending();
		return offset_q.size();
	endfunction
endclass

module tiled_texture_address_tb;
	import tta_pkg::*;

	localparam int COORD_W      = 13;
	localparam int S_W          = ((2 * COORD_W + Z_WIDTH + 7) / 8) * 8;
	localparam int PIPE_LATENCY = 4;
	localparam int HOLD_CYCLES  = 150;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 66;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_W-1:0]         s_tdata = '0;   // block_x, block_y, block_z, zero pad
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OFFSET_WIDTH-1:0] m_tdata;        // byte_offset

	offset_scoreboard sb;
	bit  hold_req;
	bit  sender_burst;
	int  settings_used;
	int  vol_items;

	bit [12:0] dir_x[10] = '{13'd0, 13'h1FFF, 13'h1FFF, 13'd0, 13'd0, 13'd5, 13'd5,
		13'd31, 13'd32, 13'h0AAA};
	bit [12:0] dir_y[10] = '{13'd0, 13'h1FFF, 13'd0, 13'h1FFF, 13'd0, 13'd9, 13'd9,
		13'd31, 13'd32, 13'h1555};
	bit [9:0]  dir_z[10] = '{10'd0, 10'h3FF, 10'd0, 10'd0, 10'h3FF, 10'd0, 10'h3FF,
		10'd3, 10'd4, 10'h155};

	tiled_texture_address #(.COORD_WIDTH(COORD_W)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (s_tvalid && s_tready)
				sb.note_input(s_tdata[12:0], s_tdata[25:13], s_tdata[35:26]);
		end
	end

	function automatic bit [12:0] pick_xy();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 13'($urandom);
			4, 5:       return 13'($urandom_range(0, 95));
			6:          return 13'h1FFF - 13'($urandom_range(0, 40));
			7, 8:       return 13'($urandom_range(0, 255) * 32) + 13'($urandom_range(0, 1))
				- 13'($urandom_range(0, 1));
			default:    return $urandom_range(0, 1) ? 13'h1FFF : 13'd0;
		endcase
	endfunction

	function automatic bit [9:0] pick_z();
		case ($urandom_range(0, 5))
			0, 1, 2: return 10'($urandom);
			3:       return 10'($urandom_range(0, 9));
			4:       return 10'h3FF - 10'($urandom_range(0, 5));
			default: return $urandom_range(0, 1) ? 10'h3FF : 10'd0;
		endcase
	endfunction

	function automatic bit [13:0] pick_extent();
		case ($urandom_range(0, 7))
			0:       return 14'd0;
			1:       return 14'd8192;
			2:       return 14'h3FFF;
			3, 4:    return 14'($urandom_range(1, 300));
			default: return 14'($urandom);
		endcase
	endfunction

	function automatic int pick_gap();
		if (sender_burst)
			return 0;
		case ($urandom_range(0, 19))
			0, 1, 2, 3: return $urandom_range(1, 3);
			4:          return $urandom_range(10, 30);
			default:    return 0;
		endcase
	endfunction

	task automatic send_item(bit [12:0] x, bit [12:0] y, bit [9:0] z);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, z, y, x};
		do @(posedge clk); while (!s_tready);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_surface(bit vm, bit [13:0] pitch, bit [13:0] height, bit [2:0] lg);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_VOLUME_MODE;
		cfg_data  <= {13'($urandom), vm};
		@(posedge clk);
		cfg_index <= REG_ROW_PITCH;
		cfg_data  <= pitch;
		@(posedge clk);
		cfg_index <= REG_SURF_HEIGHT;
		cfg_data  <= height;
		@(posedge clk);
		cfg_index <= REG_BYTES_LOG2;
		cfg_data  <= {11'($urandom), lg};
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.set_surface(vm, pitch, height, lg);
		settings_used++;
	endtask

	task automatic send_directed();
		for (int i = 0; i < 10; i++)
			send_item(dir_x[i], dir_y[i], dir_z[i]);
	endtask

	// receiver: random ready pattern, long hold-off on request
	initial begin
		int run;
		int stall;
		@(posedge clk);
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			run = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
			m_tready <= 1'b1;
			for (int i = 0; i < run && !hold_req; i++)
				@(posedge clk);
			stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			m_tready <= 1'b0;
			for (int i = 0; i < stall && !hold_req; i++)
				@(posedge clk);
		end
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		bit        vm;
		bit [13:0] pitch;
		bit [13:0] height;
		bit [2:0]  lg;
		bit [9:0]  z;
		sb = new;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: everything zero, flat tiling
		send_item(13'd0, 13'd0, 10'd0);
		send_item(13'h1FFF, 13'h1FFF, 10'h3FF);
		send_item(13'h1555, 13'h0AAA, 10'h2AA);

		set_surface(1'b0, 14'd8192, 14'd0, 3'd6);
		send_directed();
		set_surface(1'b1, 14'd8192, 14'd8192, 3'd6);
		send_directed();

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin vm = 1'b0; pitch = 14'h3FFF; height = 14'h3FFF; lg = 3'd7; end
				1: begin vm = 1'b1; pitch = 14'h3FFF; height = 14'h3FFF; lg = 3'd7; end
				2: begin vm = 1'b1; pitch = 14'd0; height = 14'd0; lg = 3'd0; end
				default: begin
					vm     = (p % 2 == 1);
					pitch  = pick_extent();
					height = pick_extent();
					lg     = 3'($urandom);
				end
			endcase
			set_surface(vm, pitch, height, lg);
			sender_burst = (p == 3) || (p == 6);
			if (p == 3)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 4 && i == PHASE_ITEMS / 2)
					wait_idle();
				z = pick_z();
				send_item(pick_xy(), pick_xy(), z);
				if (vm)
					vol_items++;
			end
		end
		sender_burst = 1'b0;

		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (PIPE_LATENCY * 4) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d offsets never returned", sb.pending()));

		$display("tb: %0d transactions in (%0d random volume), %0d offsets checked, %0d surfaces",
			sb.accepted, vol_items, sb.checked, settings_used);
		$display("tb: flat and volume tiling, pitch and height 0 to 16383, size codes 0 to 7");
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
design/tta_pkg.sv
design/tta_coord_mul.sv
design/tta_swizzle.sv
design/tiled_texture_address.sv
dv/tiled_texture_address_tb.sv
